// ===== src/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// lir_pkg
// Types and constants shared by the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 18;
  localparam int PITCH_W  = 17;
  localparam int FRAME_W  = 9;
  localparam int PROD_W   = 34;
  localparam int CFG_IDX_W = 1;

  localparam logic [PHASE_W-1:0] PHASE_ONE = 18'h10000;
  localparam logic [PITCH_W-1:0] PITCH_MIN = 17'd1024;
  localparam logic [PITCH_W-1:0] PITCH_MAX = 17'd131070;
  localparam logic [PITCH_W-1:0] PITCH_RST = 17'd65536;
  localparam logic [FRAME_W-1:0] FRAME_RST = 9'd184;
  localparam logic [FRAME_W-1:0] MAX_FRAME_OUTPUTS = 9'd511;

  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_OUTPUTS = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       frame_start;
    logic                       clear_history;
  } lir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_run;
    logic                       frame_done;
  } lir_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } lir_state_t;

endpackage

// ===== src/lir_interp_unit.sv =====
// ----------------------------------------------------------------------------
// lir_interp_unit
// Shared interpolation unit: registered (next - prev) * phase product,
// then prev plus the arithmetically shifted product, wrapped to 16 bits.
// ----------------------------------------------------------------------------
module lir_interp_unit
  import lir_pkg::*;
(
  input  logic                       clk,
  input  logic                       load,
  input  logic signed [SAMPLE_W-1:0] prev_sample,
  input  logic signed [SAMPLE_W-1:0] next_sample,
  input  logic [SAMPLE_W-1:0]        phase,
  output logic signed [SAMPLE_W-1:0] result
);

  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W:0]   phase_s;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;

  assign diff     = {next_sample[SAMPLE_W-1], next_sample}
                  - {prev_sample[SAMPLE_W-1], prev_sample};
  assign phase_s  = {1'b0, phase};
  assign prod_nxt = diff * phase_s;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign result = prev_sample + $signed(prod_r[2*SAMPLE_W-1:SAMPLE_W]);

endmodule

// ===== src/linear_interp_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation resampler with a 2.16 phase accumulator.
// ----------------------------------------------------------------------------
// Each accepted word is the next source sample. While a frame is running and
// the phase is below one, the block emits prev + ((next - prev) * phase) >> 16
// and steps the phase by the clamped pitch; the sample is consumed once the
// phase reaches one. A word is taken in the idle state and then goes through
// check states and one emit state per output; each check that goes on to an
// output also loads the single shared multiplier, and a last check ends the
// word. in_stall stays high until the word is finished. A result waits in
// the output register; an output stall holds the emit step.
// ----------------------------------------------------------------------------
module linear_interp_resampler
  import lir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lir_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lir_out_t             out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PITCH_W-1:0]   cfg_wdata
);

  lir_state_t state_r, state_nxt;

  logic [PITCH_W-1:0]        pitch_r;
  logic [FRAME_W-1:0]        frame_len_r;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_W-1:0] next_r;
  logic [PHASE_W-1:0]        phase_r, phase_nxt;
  logic [FRAME_W-1:0]        emitted_r, emitted_nxt;
  logic                      active_r, active_nxt;
  logic                      out_valid_r, out_valid_nxt;
  lir_out_t                  out_r;

  logic [PITCH_W-1:0]        pitch_eff;
  logic [FRAME_W-1:0]        len_eff;
  logic [PHASE_W-1:0]        phase_sum;
  logic [FRAME_W-1:0]        emitted_inc;
  logic                      frame_end;
  logic                      in_accept;
  logic                      out_free;
  logic                      go_emit;
  logic                      mul_load;
  logic                      out_load;
  logic signed [SAMPLE_W-1:0] interp_res;

  always_comb begin
    pitch_eff = pitch_r;
    if (pitch_r < PITCH_MIN) begin
      pitch_eff = PITCH_MIN;
    end else if (pitch_r > PITCH_MAX) begin
      pitch_eff = PITCH_MAX;
    end
    pitch_eff[0] = 1'b0;
  end

  always_comb begin
    len_eff = frame_len_r;
    if (frame_len_r == '0) begin
      len_eff = FRAME_W'(1);
    end else if (frame_len_r > MAX_FRAME_OUTPUTS) begin
      len_eff = MAX_FRAME_OUTPUTS;
    end
  end

  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign go_emit     = active_r && (phase_r < PHASE_ONE);
  assign phase_sum   = phase_r + {1'b0, pitch_eff};
  assign emitted_inc = emitted_r + FRAME_W'(1);
  assign frame_end   = (emitted_inc >= len_eff);

  lir_interp_unit u_interp (
    .clk         (clk),
    .load        (mul_load),
    .prev_sample (prev_r),
    .next_sample (next_r),
    .phase       (phase_r[SAMPLE_W-1:0]),
    .result      (interp_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (go_emit) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    mul_load    = 1'b0;
    out_load    = 1'b0;
    prev_nxt    = prev_r;
    phase_nxt   = phase_r;
    emitted_nxt = emitted_r;
    active_nxt  = active_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.frame_start) begin
          active_nxt  = 1'b1;
          emitted_nxt = '0;
          if (in_data.clear_history) begin
            prev_nxt  = '0;
            phase_nxt = '0;
          end
        end
      end
      ST_CHECK: begin
        if (go_emit) begin
          mul_load = 1'b1;
        end else if (phase_r >= PHASE_ONE) begin
          prev_nxt  = next_r;
          phase_nxt = phase_r - PHASE_ONE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          phase_nxt   = phase_sum;
          emitted_nxt = emitted_inc;
          if (frame_end) begin
            active_nxt = 1'b0;
          end
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pitch_r     <= PITCH_RST;
      frame_len_r <= FRAME_RST;
      prev_r      <= '0;
      phase_r     <= '0;
      emitted_r   <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      phase_r     <= phase_nxt;
      emitted_r   <= emitted_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PITCH_STEP:    pitch_r     <= cfg_wdata;
          CFG_FRAME_OUTPUTS: frame_len_r <= cfg_wdata[FRAME_W-1:0];
          default:           pitch_r     <= pitch_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      next_r <= in_data.sample_in;
    end
    if (out_load) begin
      out_r.sample_out  <= interp_res;
      out_r.frame_done  <= frame_end;
      out_r.last_of_run <= frame_end || (phase_sum >= PHASE_ONE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear interpolation resampler.
// ----------------------------------------------------------------------------
// A queue of source samples feeds a clocked driver. A clocked monitor compares
// every interpolated output word against a software resampler that runs with
// its own copy of the history, phase and register values. Directed frames hit
// the pitch and frame-length clamps, full-scale swings, mid-frame restarts,
// stray clears and skipped inputs. Random frames then follow under changing
// register settings and changing back-pressure on both sides.
// ----------------------------------------------------------------------------
module testbench
  import lir_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  lir_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  lir_out_t             out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PITCH_W-1:0]   cfg_wdata = '0;

  linear_interp_resampler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  lir_in_t  pending_words[$];
  lir_out_t expected_samples[$];

  int send_idle = 0;
  int recv_idle = 0;
  int words_queued = 0;
  int words_taken = 0;
  int samples_checked = 0;
  int reg_writes = 0;
  int errors = 0;

  logic [PITCH_W-1:0]         pitch_reg = PITCH_RST;
  logic [FRAME_W-1:0]         frame_reg = FRAME_RST;
  logic signed [SAMPLE_W-1:0] hist = '0;
  int                         phase = 0;
  int                         emitted = 0;
  bit                         running = 1'b0;

  function automatic int step_of();
    int p;
    p = int'(pitch_reg);
    if (p < int'(PITCH_MIN)) p = int'(PITCH_MIN);
    if (p > int'(PITCH_MAX)) p = int'(PITCH_MAX);
    return p & ~1;
  endfunction

  function automatic int len_of();
    int n;
    n = int'(frame_reg);
    if (n == 0) n = 1;
    if (n > int'(MAX_FRAME_OUTPUTS)) n = int'(MAX_FRAME_OUTPUTS);
    return n;
  endfunction

  function automatic void resample_word(input lir_in_t w);
    lir_out_t r;
    longint   prod;
    int       n;
    n = 0;
    r = '0;
    if (w.frame_start) begin
      if (w.clear_history) begin
        hist = '0;
        phase = 0;
      end
      running = 1'b1;
      emitted = 0;
    end
    while (running && phase < int'(PHASE_ONE) && n < 64) begin
      if (n > 0) expected_samples.push_back(r);
      prod = (longint'(w.sample_in) - longint'(hist)) * longint'(phase);
      r.sample_out = 16'(longint'(hist) + (prod >>> 16));
      r.last_of_run = 1'b0;
      r.frame_done = 1'b0;
      phase = phase + step_of();
      emitted = (emitted + 1) % 512;
      if (emitted >= len_of()) begin
        running = 1'b0;
        r.frame_done = 1'b1;
      end
      n++;
    end
    if (n > 0) begin
      r.last_of_run = 1'b1;
      expected_samples.push_back(r);
    end
    if (phase >= int'(PHASE_ONE)) begin
      hist = w.sample_in;
      phase = (phase - int'(PHASE_ONE)) & 'h3FFFF;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        resample_word(in_data);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lir_out_t want;
    bit       bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected output word, got %p", $time, out_data);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          bad = 1'b0;
          if (out_data.sample_out !== want.sample_out) begin
            $display("%0t: sample_out expected %0d got %0d", $time,
                     want.sample_out, out_data.sample_out);
            bad = 1'b1;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b got %0b", $time,
                     want.last_of_run, out_data.last_of_run);
            bad = 1'b1;
          end
          if (out_data.frame_done !== want.frame_done) begin
            $display("%0t: frame_done expected %0b got %0b", $time,
                     want.frame_done, out_data.frame_done);
            bad = 1'b1;
          end
          if (bad) errors++;
          samples_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic queue_word(input logic [SAMPLE_W-1:0] s, input bit start, input bit clr);
    lir_in_t w;
    w.sample_in = s;
    w.frame_start = start;
    w.clear_history = clr;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[PITCH_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_PITCH_STEP) begin
      pitch_reg = value[PITCH_W-1:0];
    end else begin
      frame_reg = value[FRAME_W-1:0];
    end
    reg_writes++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (words_taken != words_queued || expected_samples.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1: return 16'($urandom_range(0, 200)) - 16'd100;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int  p;
    int  k;
    int  n;
    int  need;
    int  phase_words;
    int  spin;
    bit  paused;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 10;
    recv_idle = 86;

    write_cfg(CFG_PITCH_STEP, 1024);
    write_cfg(CFG_FRAME_OUTPUTS, 511);
    queue_word(16'h7FFF, 1'b1, 1'b1);
    queue_word(16'h8000, 1'b0, 1'b0);
    queue_word(16'h7FFF, 1'b0, 1'b0);
    queue_word(16'h8000, 1'b0, 1'b0);
    queue_word(16'h0000, 1'b0, 1'b0);
    queue_word(16'hFFFF, 1'b0, 1'b1);
    queue_word(16'h0001, 1'b0, 1'b0);
    queue_word(16'h7FFF, 1'b0, 1'b0);
    queue_word(16'd12345, 1'b0, 1'b0);
    queue_word(16'hFFFB, 1'b0, 1'b1);
    wait_drained();

    write_cfg(CFG_PITCH_STEP, 131071);
    write_cfg(CFG_FRAME_OUTPUTS, 3);
    queue_word(16'h7FFF, 1'b1, 1'b1);
    queue_word(16'h8000, 1'b0, 1'b0);
    queue_word(16'd500, 1'b1, 1'b0);
    queue_word(16'd1000, 1'b0, 1'b0);
    queue_word(-16'sd1000, 1'b0, 1'b0);
    queue_word(16'd2000, 1'b0, 1'b0);
    wait_drained();

    write_cfg(CFG_PITCH_STEP, 0);
    write_cfg(CFG_FRAME_OUTPUTS, 0);
    queue_word(16'd300, 1'b1, 1'b0);
    queue_word(16'd400, 1'b0, 1'b0);
    queue_word(16'd400, 1'b1, 1'b1);
    wait_drained();

    for (p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle = 10;
        recv_idle = 86;
      end else if (p < 6) begin
        send_idle = 86;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (p)
        0: begin
          write_cfg(CFG_PITCH_STEP, 1024);
          write_cfg(CFG_FRAME_OUTPUTS, 511);
        end
        1: begin
          write_cfg(CFG_PITCH_STEP, 131070);
          write_cfg(CFG_FRAME_OUTPUTS, 1);
        end
        2: begin
          write_cfg(CFG_PITCH_STEP, 131071);
          write_cfg(CFG_FRAME_OUTPUTS, 0);
        end
        default: begin
          case ($urandom_range(2))
            0: write_cfg(CFG_PITCH_STEP, $urandom_range(60000, 70000));
            1: write_cfg(CFG_PITCH_STEP, $urandom_range(1024, 131070));
            default: write_cfg(CFG_PITCH_STEP, $urandom_range(0, 131071));
          endcase
          if ($urandom_range(4) == 0) begin
            write_cfg(CFG_FRAME_OUTPUTS, $urandom_range(1, 511));
          end else begin
            write_cfg(CFG_FRAME_OUTPUTS, $urandom_range(1, 40));
          end
        end
      endcase
      phase_words = 0;
      while (phase_words < 45) begin
        need = (len_of() * step_of() + 65535) / 65536 + 1;
        if (need > 40) need = 40;
        n = ($urandom_range(5) == 0) ? $urandom_range(1, need) : need;
        for (k = 0; k < n; k++) begin
          if (p == 0 && !paused && k > 0 && k == n / 2) begin
            wait_drained();
            paused = 1'b1;
          end
          queue_word(pick_sample(), k == 0 || $urandom_range(30) == 0,
                     $urandom_range(3) == 0);
        end
        phase_words += n;
        repeat ($urandom_range(0, 1)) begin
          queue_word(pick_sample(), 1'b0, $urandom_range(1));
          phase_words++;
        end
      end
      wait_drained();
    end

    do @(posedge clk);
    while (words_taken != words_queued);
    spin = 0;
    while (expected_samples.size() != 0 && spin < 200000) begin
      @(posedge clk);
      spin++;
    end
    repeat (16) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $display("%0t: %0d expected output words never arrived", $time,
               expected_samples.size());
      errors++;
    end

    $display("resampled %0d source words into %0d checked outputs", words_taken,
             samples_checked);
    $display("over %0d register writes, pitch and frame clamps included", reg_writes);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
